// File: rtl/sobol_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sobol_pkg;

  localparam int unsigned FracBits = 30;
  localparam int unsigned NDim     = 6;
  localparam int unsigned RowW     = $clog2(FracBits);
  localparam int unsigned DimsW    = 3;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned SeedRowN = 4;

  typedef enum logic [ModeW-1:0] {
    MODE_GEN     = 2'd0,
    MODE_SKIP    = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  typedef logic [FracBits-1:0]           frac_t;
  typedef logic [NDim-1:0][FracBits-1:0] coord_vec_t;
  typedef coord_vec_t [FracBits-1:0]     dir_rom_t;

  typedef struct packed {
    coord_vec_t coord;
    logic       exhausted;
  } sobol_res_t;

  localparam int PolyDegree [NDim] = '{1, 2, 3, 3, 4, 4};
  localparam int PolyBits   [NDim] = '{0, 1, 1, 2, 1, 4};
  localparam int SeedRows [SeedRowN][NDim] = '{
    '{1, 1, 1, 1, 1, 1},
    '{3, 1, 3, 3, 1, 1},
    '{5, 7, 7, 3, 3, 5},
    '{15, 11, 5, 15, 13, 9}
  };

  function automatic dir_rom_t build_dir_rom();
    dir_rom_t    rom;
    frac_t       v;
    logic [63:0] seed;
    int          deg;
    int          pb;
    rom = '0;
    for (int k = 0; k < int'(NDim); k++) begin
      deg = PolyDegree[k];
      for (int j = 1; j <= deg; j++) begin
        seed = 64'(SeedRows[j-1][k]) << (int'(FracBits) - j);
        rom[j-1][k] = seed[FracBits-1:0];
      end
      for (int j = deg + 1; j <= int'(FracBits); j++) begin
        pb = PolyBits[k];
        v  = rom[j-deg-1][k];
        v  = v ^ (v >> deg);
        for (int l = deg - 1; l >= 1; l--) begin
          if ((pb & 1) != 0) begin
            v = v ^ rom[j-l-1][k];
          end
          pb = pb >> 1;
        end
        rom[j-1][k] = v;
      end
    end
    return rom;
  endfunction

  localparam dir_rom_t DirRom = build_dir_rom();

endpackage

`default_nettype wire

// File: rtl/sobol_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sobol_core import sobol_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [ModeW-1:0] mode_i,
  input  wire logic [DimsW-1:0] dims_i,
  output logic                  res_valid_o,
  output sobol_res_t            res_o
);

  frac_t            counter_q, counter_d;
  coord_vec_t       coords_q, coords_d;
  coord_vec_t       coords_next;
  coord_vec_t       row_bits;
  logic [RowW-1:0]  row;
  logic             found;
  logic [DimsW-1:0] dims_sat;
  logic             advance;

  always_comb begin
    row   = '0;
    found = 1'b0;
    for (int i = int'(FracBits) - 1; i >= 0; i--) begin
      if (!counter_q[i]) begin
        row   = RowW'(i);
        found = 1'b1;
      end
    end
  end

  assign dims_sat = (dims_i > DimsW'(NDim)) ? DimsW'(NDim) : dims_i;
  assign row_bits = DirRom[row];

  always_comb begin
    for (int k = 0; k < int'(NDim); k++) begin
      coords_next[k] = (DimsW'(k) < dims_sat) ? (coords_q[k] ^ row_bits[k]) : coords_q[k];
    end
  end

  always_comb begin
    counter_d   = counter_q;
    coords_d    = coords_q;
    advance     = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      unique case (mode_i)
        MODE_GEN: begin
          res_valid_o = 1'b1;
          if (found) begin
            advance = 1'b1;
            for (int k = 0; k < int'(NDim); k++) begin
              res_o.coord[k] = (DimsW'(k) < dims_sat) ? coords_next[k] : '0;
            end
          end else begin
            res_o.exhausted = 1'b1;
          end
        end
        MODE_SKIP: begin
          advance = found;
        end
        MODE_RESTART: begin
          counter_d = '0;
          coords_d  = '0;
        end
        default: begin
        end
      endcase
      if (advance) begin
        counter_d = counter_q + frac_t'(1);
        coords_d  = coords_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
      coords_q  <= '0;
    end else begin
      counter_q <= counter_d;
      coords_q  <= coords_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sobol_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module sobol_skid import sobol_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire sobol_res_t  push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output sobol_res_t       out_data_o
);

  logic       out_valid_q, out_valid_d;
  logic       skid_valid_q, skid_valid_d;
  sobol_res_t out_data_q, out_data_d;
  sobol_res_t skid_data_q, skid_data_d;
  logic       out_busy;

  assign out_busy = out_valid_q && out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_busy) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: rtl/sobol_sequence_generator_unit.sv
// Sobol quasi-random point generator, six dimensions, 30-bit fractions.
// Input channel (in_valid_i / in_stall_o): one request carries mode_i and
// dims_i. Generate emits one point, skip advances silently, restart clears
// the point counter and running coordinates; mode 3 is ignored.
// Output channel (out_valid_o / out_stall_i): coord_1_o..coord_6_o and
// exhausted_o. Coordinates past dims_i read zero; once the counter is all
// ones, generate returns exhausted_o high with zero coordinates and holds.
// An accepted result is registered in the output register, or in the
// skid entry while the receiver stalls. Throughput: one request per
// cycle while in_stall_o is low; the counter priority encode, one direction
// ROM row and six XORs are combinational. Stall: an output register plus
// one skid entry; in_stall_o rises only when the skid entry is occupied,
// set when the receiver stalls with a result pending and another arrives.
// Reset: asynchronous, clears the counter, coordinates and the valid flags of both buffers.
`timescale 1ns / 1ps
`default_nettype none

module sobol_sequence_generator_unit import sobol_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ModeW-1:0]    mode_i,
  input  wire logic [DimsW-1:0]    dims_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [FracBits-1:0] coord_1_o,
  output logic      [FracBits-1:0] coord_2_o,
  output logic      [FracBits-1:0] coord_3_o,
  output logic      [FracBits-1:0] coord_4_o,
  output logic      [FracBits-1:0] coord_5_o,
  output logic      [FracBits-1:0] coord_6_o,
  output logic                     exhausted_o
);

  logic       accept;
  logic       res_valid;
  logic       full;
  sobol_res_t res;
  sobol_res_t out_data;

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  sobol_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .dims_i      (dims_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sobol_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign coord_1_o   = out_data.coord[0];
  assign coord_2_o   = out_data.coord[1];
  assign coord_3_o   = out_data.coord[2];
  assign coord_4_o   = out_data.coord[3];
  assign coord_5_o   = out_data.coord[4];
  assign coord_6_o   = out_data.coord[5];
  assign exhausted_o = out_data.exhausted;

endmodule

`default_nettype wire
